/* rtl/collision_impulse_resolver_assert.svh */
// ----------------------------------------------------------------------------
// collision impulse resolver assertion macros
// shared property forms for the block's checker
// ----------------------------------------------------------------------------
`ifndef COLLISION_IMPULSE_RESOLVER_ASSERT_SVH
`define COLLISION_IMPULSE_RESOLVER_ASSERT_SVH

// same-cycle implication, off during reset
`define CIR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cir assertion failed");

// next-cycle implication, off during reset
`define CIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cir assertion failed");

// next-cycle implication that also holds across reset
`define CIR_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cir assertion failed");

`endif

/* rtl/cir_pkg.sv */
// ----------------------------------------------------------------------------
// cir_pkg
// payload types and register codes of the collision impulse resolver
// ----------------------------------------------------------------------------
package cir_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_CORRECTION_PERCENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENETRATION_SLOP   = 1'd1;

   localparam logic [16:0] CORRECTION_PERCENT_RESET = 17'd32768;
   localparam logic [30:0] PENETRATION_SLOP_RESET   = 31'd1311;
   localparam logic [16:0] Q_ONE                    = 17'd65536;

   typedef struct packed {
      logic [63:0] contact_normal;
      logic [30:0] penetration_depth;
      logic [63:0] position_first;
      logic [63:0] position_second;
      logic [63:0] velocity_first;
      logic [63:0] velocity_second;
      logic [30:0] inv_mass_first;
      logic [30:0] inv_mass_second;
      logic [16:0] restitution_first;
      logic [16:0] restitution_second;
   } req_type;

   typedef struct packed {
      logic [63:0] new_position_first;
      logic [63:0] new_position_second;
      logic [63:0] new_velocity_first;
      logic [63:0] new_velocity_second;
      logic        separating;
      logic        degenerate;
   } rsp_type;

endpackage

/* rtl/collision_impulse_resolver.sv */
// ----------------------------------------------------------------------------
// collision_impulse_resolver
// pipelined 2d contact resolution: positional correction and restitution impulse
// ----------------------------------------------------------------------------
// req channel: one contact per transaction (normal, depth, both bodies' state).
// rsp channel: corrected positions and velocities plus separating/degenerate
// flags, one transaction per request, in request order.
// csr port: write-only, correction percent at index 0, penetration slop at 1;
// the user must write it only while the pipeline is empty; the block itself
// does not enforce this.
// throughput: one contact per cycle while the output is not stalled; the
// 33-stage restoring divider that forms each body's inverse-mass share takes
// one quotient bit per stage and sets most of the depth.
// reset clears all pipeline valid bits and the output valid bit and loads the
// register defaults (percent 0.5, slop 0.02).
// a stalled result holds in the output register; the whole pipeline freezes
// and req_stall rises while the held result is not taken, so nothing is lost.
// ----------------------------------------------------------------------------
module collision_impulse_resolver #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cir_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cir_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [cir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cir_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cir_pkg::*;

   localparam int LANE_SH   = 32 - COORD_WIDTH;
   localparam int DIV_STEPS = 33;
   localparam int ST_MUL0   = 1;
   localparam int ST_DOT    = 2;
   localparam int ST_KMUL   = 3;
   localparam int ST_KK     = 4;
   localparam int ST_FRAC   = DIV_STEPS + 1;
   localparam int ST_MUL1   = ST_FRAC + 1;
   localparam int ST_JSUM   = ST_MUL1 + 1;
   localparam int ST_POS    = ST_JSUM + 1;
   localparam int ST_VSUM   = ST_POS + 1;
   localparam int ST_VOUT   = ST_VSUM + 1;
   localparam int LAST      = ST_VOUT;

   localparam logic signed [67:0] SAT_MAX = (68'sd1 <<< (COORD_WIDTH - 1)) - 68'sd1;
   localparam logic signed [67:0] SAT_MIN = -SAT_MAX - 68'sd1;

   typedef struct packed {
      logic signed [31:0] nx, ny, pax, pay, pbx, pby, vax, vay, vbx, vby;
      logic        [31:0] sum;
      logic               degen;
      logic        [30:0] excess;
      logic        [16:0] emin;
      logic signed [32:0] rx, ry;
      logic        [47:0] eprod;
      logic signed [64:0] dpx, dpy;
      logic        [30:0] ecorr;
      logic signed [49:0] dot;
      logic        [64:0] kprod;
      logic        [49:0] kk;
      logic        [32:0] rem, quo;
      logic        [32:0] fa, fb;
      logic        [30:0] sa, sb;
      logic        [64:0] kalo, kblo;
      logic        [50:0] kahi, kbhi;
      logic        [49:0] ja, jb;
      logic signed [63:0] dpax, dpay, dpbx, dpby;
      logic        [31:0] opax, opay, opbx, opby;
      logic signed [64:0] lax, lay, lbx, lby;
      logic signed [50:0] hax, hay, hbx, hby;
      logic signed [66:0] dvax, dvay, dvbx, dvby;
      logic        [31:0] ovax, ovay, ovbx, ovby;
   } ctx_type;

   function automatic logic signed [31:0] lane(input logic [31:0] w);
      return $signed(w << LANE_SH) >>> LANE_SH;
   endfunction

   function automatic logic [31:0] sat(input logic signed [67:0] v);
      logic signed [67:0] r;
      if (v > SAT_MAX) r = SAT_MAX;
      else if (v < SAT_MIN) r = SAT_MIN;
      else r = v;
      return r[31:0];
   endfunction

   logic [16:0] pct_ff;
   logic [30:0] slop_ff;
   logic [16:0] pct_eff;
   logic        adv;
   logic [LAST:0] vld_ff;
   ctx_type     ctx_ff [0:LAST];
   ctx_type     ctx_in [0:LAST];
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;

   // pipeline moves whenever the output register is free or being drained
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pct_eff   = (pct_ff > Q_ONE) ? Q_ONE : pct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff  <= CORRECTION_PERCENT_RESET;
         slop_ff <= PENETRATION_SLOP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CORRECTION_PERCENT: pct_ff  <= csr_wdata[16:0];
            CSR_PENETRATION_SLOP:   slop_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      logic [32:0] trial;
      logic [16:0] rmin;
      logic [47:0] dotu;
      ctx_type     c;

      ctx_in[0] = '0;
      for (int i = 1; i <= LAST; i++) begin
         ctx_in[i] = ctx_ff[i-1];
      end

      // decode and first sums
      ctx_in[0].nx  = lane(req_data.contact_normal[63:32]);
      ctx_in[0].ny  = lane(req_data.contact_normal[31:0]);
      ctx_in[0].pax = lane(req_data.position_first[63:32]);
      ctx_in[0].pay = lane(req_data.position_first[31:0]);
      ctx_in[0].pbx = lane(req_data.position_second[63:32]);
      ctx_in[0].pby = lane(req_data.position_second[31:0]);
      ctx_in[0].vax = lane(req_data.velocity_first[63:32]);
      ctx_in[0].vay = lane(req_data.velocity_first[31:0]);
      ctx_in[0].vbx = lane(req_data.velocity_second[63:32]);
      ctx_in[0].vby = lane(req_data.velocity_second[31:0]);
      ctx_in[0].rx  = 33'(ctx_in[0].vax) - 33'(ctx_in[0].vbx);
      ctx_in[0].ry  = 33'(ctx_in[0].vay) - 33'(ctx_in[0].vby);
      ctx_in[0].sum = 32'(req_data.inv_mass_first) + 32'(req_data.inv_mass_second);
      ctx_in[0].degen  = (ctx_in[0].sum == '0);
      ctx_in[0].excess = (req_data.penetration_depth > slop_ff)
                       ? req_data.penetration_depth - slop_ff : '0;
      rmin = (req_data.restitution_first < req_data.restitution_second)
           ? req_data.restitution_first : req_data.restitution_second;
      ctx_in[0].emin = (rmin > Q_ONE) ? Q_ONE : rmin;
      ctx_in[0].rem  = 33'(req_data.inv_mass_first);
      ctx_in[0].quo  = '0;

      // correction depth and closing speed products
      c = ctx_ff[ST_MUL0-1];
      ctx_in[ST_MUL0].eprod = 48'(c.excess) * 48'(pct_eff);
      ctx_in[ST_MUL0].dpx   = 65'(c.nx) * 65'(c.rx);
      ctx_in[ST_MUL0].dpy   = 65'(c.ny) * 65'(c.ry);

      c = ctx_ff[ST_DOT-1];
      ctx_in[ST_DOT].ecorr = c.eprod[46:16];
      ctx_in[ST_DOT].dot   = 50'(c.dpx >>> 16) + 50'(c.dpy >>> 16);

      // restitution scale, only used when the closing speed is not negative
      c = ctx_ff[ST_KMUL-1];
      dotu = c.dot[47:0];
      ctx_in[ST_KMUL].kprod = 65'(dotu) * 65'(c.emin);

      c = ctx_ff[ST_KK-1];
      dotu = c.dot[47:0];
      ctx_in[ST_KK].kk = 50'(dotu) + 50'(c.kprod[64:16]);

      // restoring division of ima * 2^32 by the inverse-mass sum, one bit a stage
      for (int j = 1; j <= DIV_STEPS; j++) begin
         c = ctx_ff[j-1];
         trial = (j == 1) ? c.rem : {c.rem[31:0], 1'b0};
         if (trial >= {1'b0, c.sum}) begin
            ctx_in[j].rem = trial - {1'b0, c.sum};
            ctx_in[j].quo = {c.quo[31:0], 1'b1};
         end else begin
            ctx_in[j].rem = trial;
            ctx_in[j].quo = {c.quo[31:0], 1'b0};
         end
      end

      // second body share follows from the first share and the remainder
      c = ctx_ff[ST_FRAC-1];
      ctx_in[ST_FRAC].fa = c.quo;
      ctx_in[ST_FRAC].fb = 33'h1_0000_0000 - c.quo - 33'(c.rem != '0);

      c = ctx_ff[ST_MUL1-1];
      ctx_in[ST_MUL1].sa   = 31'((64'(c.ecorr) * 64'(c.fa)) >> 32);
      ctx_in[ST_MUL1].sb   = 31'((64'(c.ecorr) * 64'(c.fb)) >> 32);
      ctx_in[ST_MUL1].kalo = 65'(c.kk[31:0]) * 65'(c.fa);
      ctx_in[ST_MUL1].kblo = 65'(c.kk[31:0]) * 65'(c.fb);
      ctx_in[ST_MUL1].kahi = 51'(c.kk[49:32]) * 51'(c.fa);
      ctx_in[ST_MUL1].kbhi = 51'(c.kk[49:32]) * 51'(c.fb);

      c = ctx_ff[ST_JSUM-1];
      ctx_in[ST_JSUM].ja   = 50'(c.kahi + 51'(c.kalo[64:32]));
      ctx_in[ST_JSUM].jb   = 50'(c.kbhi + 51'(c.kblo[64:32]));
      ctx_in[ST_JSUM].dpax = 64'(c.nx) * 64'($signed({1'b0, c.sa}));
      ctx_in[ST_JSUM].dpay = 64'(c.ny) * 64'($signed({1'b0, c.sa}));
      ctx_in[ST_JSUM].dpbx = 64'(c.nx) * 64'($signed({1'b0, c.sb}));
      ctx_in[ST_JSUM].dpby = 64'(c.ny) * 64'($signed({1'b0, c.sb}));

      c = ctx_ff[ST_POS-1];
      ctx_in[ST_POS].opax = sat(68'(c.pax) - 68'(c.dpax >>> 16));
      ctx_in[ST_POS].opay = sat(68'(c.pay) - 68'(c.dpay >>> 16));
      ctx_in[ST_POS].opbx = sat(68'(c.pbx) + 68'(c.dpbx >>> 16));
      ctx_in[ST_POS].opby = sat(68'(c.pby) + 68'(c.dpby >>> 16));
      ctx_in[ST_POS].lax  = 65'(c.nx) * 65'($signed({1'b0, c.ja[31:0]}));
      ctx_in[ST_POS].lay  = 65'(c.ny) * 65'($signed({1'b0, c.ja[31:0]}));
      ctx_in[ST_POS].lbx  = 65'(c.nx) * 65'($signed({1'b0, c.jb[31:0]}));
      ctx_in[ST_POS].lby  = 65'(c.ny) * 65'($signed({1'b0, c.jb[31:0]}));
      ctx_in[ST_POS].hax  = 51'(c.nx) * 51'($signed({1'b0, c.ja[49:32]}));
      ctx_in[ST_POS].hay  = 51'(c.ny) * 51'($signed({1'b0, c.ja[49:32]}));
      ctx_in[ST_POS].hbx  = 51'(c.nx) * 51'($signed({1'b0, c.jb[49:32]}));
      ctx_in[ST_POS].hby  = 51'(c.ny) * 51'($signed({1'b0, c.jb[49:32]}));

      c = ctx_ff[ST_VSUM-1];
      ctx_in[ST_VSUM].dvax = 67'((83'(c.lax) + (83'(c.hax) <<< 32)) >>> 16);
      ctx_in[ST_VSUM].dvay = 67'((83'(c.lay) + (83'(c.hay) <<< 32)) >>> 16);
      ctx_in[ST_VSUM].dvbx = 67'((83'(c.lbx) + (83'(c.hbx) <<< 32)) >>> 16);
      ctx_in[ST_VSUM].dvby = 67'((83'(c.lby) + (83'(c.hby) <<< 32)) >>> 16);

      c = ctx_ff[ST_VOUT-1];
      ctx_in[ST_VOUT].ovax = sat(68'(c.vax) - 68'(c.dvax));
      ctx_in[ST_VOUT].ovay = sat(68'(c.vay) - 68'(c.dvay));
      ctx_in[ST_VOUT].ovbx = sat(68'(c.vbx) + 68'(c.dvbx));
      ctx_in[ST_VOUT].ovby = sat(68'(c.vby) + 68'(c.dvby));
   end

   // final select between resolved and passed-through values
   always_comb begin
      ctx_type c;
      logic    sep;
      c   = ctx_ff[LAST];
      sep = !c.degen && c.dot[49];
      rsp_data_in.degenerate = c.degen;
      rsp_data_in.separating = sep;
      if (c.degen) begin
         rsp_data_in.new_position_first  = {c.pax, c.pay};
         rsp_data_in.new_position_second = {c.pbx, c.pby};
      end else begin
         rsp_data_in.new_position_first  = {c.opax, c.opay};
         rsp_data_in.new_position_second = {c.opbx, c.opby};
      end
      if (c.degen || sep) begin
         rsp_data_in.new_velocity_first  = {c.vax, c.vay};
         rsp_data_in.new_velocity_second = {c.vbx, c.vby};
      end else begin
         rsp_data_in.new_velocity_first  = {c.ovax, c.ovay};
         rsp_data_in.new_velocity_second = {c.ovbx, c.ovby};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAST-1:0], req_valid};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= LAST; i++) begin
            ctx_ff[i] <= ctx_in[i];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/cir_checker.sv */
// ----------------------------------------------------------------------------
// cir_checker
// port-level checks of the collision impulse resolver, bound to the top level
// ----------------------------------------------------------------------------
`include "collision_impulse_resolver_assert.svh"

module cir_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cir_pkg::rsp_type rsp_data
);
   import cir_pkg::*;

   // input side only backs up behind a held result
   `CIR_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // a zero mass sum never reports a separating contact
   `CIR_ASSERT_IMPL(a_flags_excl, clock, reset, rsp_valid,
                    !(rsp_data.separating && rsp_data.degenerate))
   `CIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CIR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // nothing comes out of a freshly reset pipeline
   `CIR_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind collision_impulse_resolver cir_checker u_cir_checker (.*);

/* sim/collision_impulse_resolver_tb.sv */
// ----------------------------------------------------------------------------
// collision_impulse_resolver_tb
// self-checking bench for the 2d contact resolver
// ----------------------------------------------------------------------------
// contacts are driven on the req channel with random gaps. Each accepted
// contact is resolved by a fixed-point predictor in the bench, and the result
// is queued. Every rsp transaction is checked field by field against the
// oldest queued result. The csr registers are swept through several settings
// while the pipeline is empty. The rsp side applies random stall.
// ----------------------------------------------------------------------------
module collision_impulse_resolver_tb;
   import cir_pkg::*;

   localparam longint unsigned PROD_CLAMP = 64'h4000_0000_0000_0000;
   localparam int PIPE_DEPTH = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow copies of the csr registers
   logic [16:0] pct_shadow;
   logic [30:0] slop_shadow;

   rsp_type resolved_queue[$];
   int      error_count;
   int      contacts_sent;
   int      results_checked;
   int      degenerate_seen;
   int      separating_seen;
   int      csr_writes;
   bit      req_idling;
   bit      rsp_idling;
   int      rsp_hold;

   collision_impulse_resolver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint lane_value(logic [31:0] w);
      return longint'(signed'(w));
   endfunction

   function automatic logic [31:0] lane_sat(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // floor(a*b / 2^s) with the magnitude of the result clamped to 2^62
   function automatic longint mul_floor(longint a, longint b, int s);
      longint unsigned ma;
      longint unsigned mb;
      logic [127:0]    prod;
      logic [127:0]    q;
      bit              neg;
      bit              frac;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      q    = prod >> s;
      frac = (prod & ((128'd1 << s) - 128'd1)) != 128'd0;
      if (q > PROD_CLAMP) q = PROD_CLAMP;
      else if (neg && frac && q < PROD_CLAMP) q = q + 128'd1;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic rsp_type resolve_contact(req_type c);
      rsp_type         r;
      longint          n[2], pa[2], pb[2], va[2], vb[2];
      longint unsigned mass_sum;
      longint unsigned pct, excess, e;
      longint          e_corr, fa, fb, sa, sb, dot, kk, ja, jb;
      for (int k = 0; k < 2; k++) begin
         n[k]  = lane_value(k == 0 ? c.contact_normal[63:32]  : c.contact_normal[31:0]);
         pa[k] = lane_value(k == 0 ? c.position_first[63:32]  : c.position_first[31:0]);
         pb[k] = lane_value(k == 0 ? c.position_second[63:32] : c.position_second[31:0]);
         va[k] = lane_value(k == 0 ? c.velocity_first[63:32]  : c.velocity_first[31:0]);
         vb[k] = lane_value(k == 0 ? c.velocity_second[63:32] : c.velocity_second[31:0]);
      end
      r.separating = 1'b0;
      r.degenerate = 1'b0;
      mass_sum = longint'(c.inv_mass_first) + longint'(c.inv_mass_second);
      if (mass_sum == 0) begin
         r.degenerate = 1'b1;
      end else begin
         pct    = (pct_shadow > Q_ONE) ? Q_ONE : pct_shadow;
         excess = (c.penetration_depth > slop_shadow) ?
                  c.penetration_depth - slop_shadow : 0;
         e_corr = (excess * pct) >> 16;
         fa     = ({33'd0, c.inv_mass_first} << 32) / mass_sum;
         fb     = ({33'd0, c.inv_mass_second} << 32) / mass_sum;
         sa     = mul_floor(e_corr, fa, 32);
         sb     = mul_floor(e_corr, fb, 32);
         dot    = 0;
         for (int k = 0; k < 2; k++) begin
            pa[k] -= mul_floor(n[k], sa, 16);
            pb[k] += mul_floor(n[k], sb, 16);
            dot   += mul_floor(n[k], va[k] - vb[k], 16);
         end
         if (dot < 0) begin
            r.separating = 1'b1;
         end else begin
            e = (c.restitution_first < c.restitution_second) ?
                c.restitution_first : c.restitution_second;
            if (e > Q_ONE) e = Q_ONE;
            kk = dot + mul_floor(dot, e, 16);
            ja = mul_floor(kk, fa, 32);
            jb = mul_floor(kk, fb, 32);
            for (int k = 0; k < 2; k++) begin
               va[k] -= mul_floor(n[k], ja, 16);
               vb[k] += mul_floor(n[k], jb, 16);
            end
         end
      end
      r.new_position_first  = {lane_sat(pa[0]), lane_sat(pa[1])};
      r.new_position_second = {lane_sat(pb[0]), lane_sat(pb[1])};
      r.new_velocity_first  = {lane_sat(va[0]), lane_sat(va[1])};
      r.new_velocity_second = {lane_sat(vb[0]), lane_sat(vb[1])};
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, actual %h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      int      hold_draw;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (resolved_queue.size() == 0) begin
               $error("unexpected rsp transaction: %h", rsp_data);
               error_count++;
            end else begin
               exp_r = resolved_queue.pop_front();
               compare_field("new_position_first", exp_r.new_position_first,
                             rsp_data.new_position_first);
               compare_field("new_position_second", exp_r.new_position_second,
                             rsp_data.new_position_second);
               compare_field("new_velocity_first", exp_r.new_velocity_first,
                             rsp_data.new_velocity_first);
               compare_field("new_velocity_second", exp_r.new_velocity_second,
                             rsp_data.new_velocity_second);
               compare_field("separating", 64'(exp_r.separating),
                             64'(rsp_data.separating));
               compare_field("degenerate", 64'(exp_r.degenerate),
                             64'(rsp_data.degenerate));
               results_checked++;
               degenerate_seen += exp_r.degenerate;
               separating_seen += exp_r.separating;
            end
            // wait a drawn number of cycles before taking the next transaction
            hold_draw = rsp_idling ? int'($urandom_range(14, 0)) : 0;
            rsp_hold  <= hold_draw;
            rsp_stall <= (hold_draw != 0);
         end else if (rsp_hold > 0) begin
            rsp_stall <= (rsp_hold > 1);
            rsp_hold  <= rsp_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   // entered and left just after a rising edge
   task automatic send_contact(req_type c);
      int gap;
      gap = req_idling ? int'($urandom_range(14, 0)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      resolved_queue.push_back(resolve_contact(c));
      contacts_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (resolved_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CORRECTION_PERCENT) pct_shadow = value[16:0];
      else slop_shadow = value;
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic set_config(logic [16:0] pct, logic [30:0] slop);
      drain_pipeline();
      write_csr(CSR_CORRECTION_PERCENT, CSR_DATA_W'(pct));
      write_csr(CSR_PENETRATION_SLOP, slop);
   endtask

   function automatic logic [63:0] pick_normal();
      logic [31:0] a;
      logic [31:0] b;
      case ($urandom_range(5, 0))
         0: begin a = 32'd65536; b = 32'd0; end
         1: begin a = 32'd0; b = 32'd65536; end
         2: begin a = 32'd46341; b = 32'd46341; end
         3: begin a = 32'd39322; b = 32'd52429; end
         4: begin a = $urandom_range(65536, 0); b = $urandom_range(65536, 0); end
         default: return {$urandom, $urandom};
      endcase
      if ($urandom_range(1, 0)) a = -a;
      if ($urandom_range(1, 0)) b = -b;
      return {a, b};
   endfunction

   function automatic logic [63:0] pick_vector(int scale);
      logic [31:0] a;
      logic [31:0] b;
      if ($urandom_range(7, 0) == 0) return {$urandom, $urandom};
      a = $urandom_range(scale, 0);
      b = $urandom_range(scale, 0);
      if ($urandom_range(1, 0)) a = -a;
      if ($urandom_range(1, 0)) b = -b;
      return {a, b};
   endfunction

   function automatic logic [30:0] pick_mass();
      case ($urandom_range(7, 0))
         0: return 31'd0;
         1: return 31'($urandom);
         default: return 31'($urandom_range(4 * 65536, 1));
      endcase
   endfunction

   function automatic req_type random_contact();
      req_type c;
      c.contact_normal     = pick_normal();
      c.penetration_depth  = ($urandom_range(5, 0) == 0) ? 31'($urandom) :
                             31'($urandom_range(8 * 65536, 0));
      c.position_first     = pick_vector(1000 * 65536);
      c.position_second    = pick_vector(1000 * 65536);
      c.velocity_first     = pick_vector(50 * 65536);
      c.velocity_second    = pick_vector(50 * 65536);
      c.inv_mass_first     = pick_mass();
      c.inv_mass_second    = pick_mass();
      c.restitution_first  = ($urandom_range(9, 0) == 0) ? 17'($urandom) :
                             17'($urandom_range(65536, 0));
      c.restitution_second = ($urandom_range(9, 0) == 0) ? 17'($urandom) :
                             17'($urandom_range(65536, 0));
      return c;
   endfunction

   function automatic req_type base_contact();
      req_type c;
      c.contact_normal     = {32'd65536, 32'd0};
      c.penetration_depth  = 31'd65536;
      c.position_first     = {32'd0, 32'd0};
      c.position_second    = {32'd65536, 32'd0};
      c.velocity_first     = {32'd131072, 32'd0};
      c.velocity_second    = {-32'd65536, 32'd0};
      c.inv_mass_first     = 31'd65536;
      c.inv_mass_second    = 31'd32768;
      c.restitution_first  = 17'd32768;
      c.restitution_second = 17'd49152;
      return c;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed_cases();
      req_type c;
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      send_contact(base_contact());
      // both bodies immovable
      c = base_contact(); c.inv_mass_first = 31'd0; c.inv_mass_second = 31'd0;
      send_contact(c);
      // one immovable body
      c = base_contact(); c.inv_mass_second = 31'd0;
      send_contact(c);
      // bodies moving apart
      c = base_contact(); c.velocity_first = {-32'd131072, 32'd0};
      send_contact(c);
      // overlap within the slop
      c = base_contact(); c.penetration_depth = 31'd1311;
      send_contact(c);
      c = base_contact(); c.penetration_depth = 31'd1312;
      send_contact(c);
      // restitution beyond one
      c = base_contact(); c.restitution_first = 17'h1FFFF; c.restitution_second = 17'h1FFFF;
      send_contact(c);
      c = base_contact(); c.restitution_first = 17'd0;
      send_contact(c);
      // saturation of positions and velocities
      c = base_contact();
      c.contact_normal    = {32'h7FFF_FFFF, 32'h8000_0000};
      c.penetration_depth = 31'h7FFF_FFFF;
      c.position_first    = {32'h7FFF_FFFF, 32'h8000_0000};
      c.position_second   = {32'h8000_0000, 32'h7FFF_FFFF};
      c.velocity_first    = {32'h7FFF_FFFF, 32'h8000_0000};
      c.velocity_second   = {32'h8000_0000, 32'h7FFF_FFFF};
      c.inv_mass_first    = 31'h7FFF_FFFF;
      c.inv_mass_second   = 31'h7FFF_FFFF;
      send_contact(c);
      c = '1;
      send_contact(c);
      c = '0;
      send_contact(c);
      c = base_contact(); c.contact_normal = {32'h8000_0000, 32'h8000_0000};
      c.inv_mass_first = 31'h7FFF_FFFF; c.inv_mass_second = 31'd1;
      send_contact(c);
      c = base_contact(); c.contact_normal = {32'd46341, -32'd46341};
      c.velocity_first = {32'd0, -32'd655360};
      send_contact(c);
      // exactly zero closing speed
      c = base_contact(); c.velocity_first = c.velocity_second;
      send_contact(c);
      drain_pipeline();
   endtask

   task automatic test_register_extremes();
      logic [16:0] pct_set[5]  = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd32768};
      logic [30:0] slop_set[5] = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd0, 31'd1311};
      for (int s = 0; s < 5; s++) begin
         set_config(pct_set[s], slop_set[s]);
         req_idling = s[0];
         rsp_idling = s[1];
         for (int i = 0; i < 12; i++) send_contact(random_contact());
      end
      drain_pipeline();
   endtask

   task automatic test_random_contacts();
      for (int i = 0; i < 880; i++) begin
         if (i % 110 == 0) begin
            req_idling = $urandom_range(3, 0) != 0;
            rsp_idling = $urandom_range(3, 0) != 0;
         end
         // hold the sender until the pipeline has emptied, then load new csr settings
         if (i % 220 == 219) begin
            drain_pipeline();
            set_config(17'($urandom_range(65536 + 8192, 0)),
                       31'($urandom_range(131072, 0)));
         end
         send_contact(random_contact());
      end
      drain_pipeline();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      pct_shadow  = CORRECTION_PERCENT_RESET;
      slop_shadow = PENETRATION_SLOP_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_extremes();
      test_random_contacts();
      $display("checked %0d of %0d contacts, %0d degenerate, %0d separating, %0d csr writes",
               results_checked, contacts_sent, degenerate_seen, separating_seen, csr_writes);
      if (error_count == 0 && resolved_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("timeout with %0d results outstanding", resolved_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
